FILE: src/sfp_pkg.sv
// Shared types, codes and the CRC-CCITT byte update for the sync frame parser.
// No dependencies; every other file of the parser but sfp_ram takes names from here by scope.
`default_nettype none

package sfp_pkg;

    // Sizes fixed by the field widths
    localparam int PLEN_W                = 7;
    localparam int DEFAULT_PAYLOAD_DEPTH = 64;

    // Configuration register indexes
    localparam logic [2:0] REG_CHECKSUM_MODE   = 3'd0;
    localparam logic [2:0] REG_STUFFING_ENABLE = 3'd1;
    localparam logic [2:0] REG_LENGTH_MINIMUM  = 3'd2;
    localparam logic [2:0] REG_LENGTH_MAXIMUM  = 3'd3;
    localparam logic [2:0] REG_CODE_START      = 3'd4;
    localparam logic [2:0] REG_CODE_STOP       = 3'd5;
    localparam logic [2:0] REG_CODE_PING       = 3'd6;
    localparam logic [2:0] REG_CODE_RESET      = 3'd7;

    // Result status codes
    localparam logic [1:0] STATUS_ABSORB = 2'd0;
    localparam logic [1:0] STATUS_REJECT = 2'd1;
    localparam logic [1:0] STATUS_VALID  = 2'd2;

    // Frame kind codes
    localparam logic [2:0] KIND_START   = 3'd0;
    localparam logic [2:0] KIND_STOP    = 3'd1;
    localparam logic [2:0] KIND_PING    = 3'd2;
    localparam logic [2:0] KIND_RESET   = 3'd3;
    localparam logic [2:0] KIND_UNKNOWN = 3'd4;

    // Link bytes and check constants
    localparam logic [7:0]  FRAME_FLAG = 8'hAA;
    localparam logic [7:0]  ESC_BYTE   = 8'h7D;
    localparam logic [7:0]  ESC_XOR    = 8'h20;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'h1021;
    localparam logic [15:0] CNT_MAX    = 16'hFFFF;

    // Configuration seen by the front end
    typedef struct packed {
        logic       checksum_mode;
        logic       stuffing_enable;
        logic [7:0] length_minimum;
        logic [7:0] length_maximum;
        logic [7:0] code_start;
        logic [7:0] code_stop;
        logic [7:0] code_ping;
        logic [7:0] code_reset;
    } cfg_t;

    // One queued command: a single result, or a whole valid frame to drain
    typedef struct packed {
        logic              is_frame;
        logic [1:0]        status;
        logic [2:0]        kind;
        logic [7:0]        ftype;
        logic [PLEN_W-1:0] plen;
        logic [15:0]       inv_cnt;
    } cmd_t;

    // CRC-CCITT, MSB first, one byte
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] d);
        logic [15:0] c;
        c = crc_in ^ {d, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: src/sfp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module sfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                                   aclk,
    input  wire logic                                   wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                       wr_data,
    input  wire logic                                   rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: src/sfp_front.sv
// Front end: unstuffs bytes, walks the frame layout, updates the check and
// stores payload bytes. Pushes one command per beat. Uses sfp_pkg.
`default_nettype none

module sfp_front #(
    parameter int PAYLOAD_DEPTH = sfp_pkg::DEFAULT_PAYLOAD_DEPTH
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire sfp_pkg::cfg_t        cfg,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [7:0]           s_rx_byte,
    output logic                      q_push,
    output sfp_pkg::cmd_t             q_push_data,
    input  wire logic                 q_full,
    input  wire logic                 frame_done,
    output logic                      ram_wr_en,
    output logic [((PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1)-1:0] ram_wr_addr,
    output logic [7:0]                ram_wr_data
);

    localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
    localparam int CW = $clog2(PAYLOAD_DEPTH + 1);

    localparam logic [2:0] PH_SYNC  = 3'd0;
    localparam logic [2:0] PH_LEN   = 3'd1;
    localparam logic [2:0] PH_TYPE  = 3'd2;
    localparam logic [2:0] PH_DATA  = 3'd3;
    localparam logic [2:0] PH_CRCLO = 3'd4;

    logic [2:0]    phase_reg, phase_next;
    logic          unstuff_reg, unstuff_next;
    logic [7:0]    flen_reg, flen_next;
    logic [7:0]    ftype_reg, ftype_next;
    logic [CW-1:0] pcount_reg, pcount_next;
    logic [15:0]   acc_reg, acc_next;
    logic [7:0]    chk_hi_reg, chk_hi_next;
    logic [15:0]   inv_reg, inv_next;
    logic          pend_reg, pend_next;

    logic          s_fire;
    logic [7:0]    b;
    logic          skip;
    logic          do_reject;
    logic          do_bump;
    logic          do_frame;
    logic [7:0]    chk_len;
    logic [7:0]    plen_lim;
    logic [2:0]    kind;
    sfp_pkg::cmd_t cmd;

    function automatic logic [15:0] acc_add(input logic mode, input logic [15:0] acc,
                                            input logic [7:0] d);
        logic [15:0] r;
        if (mode) begin
            r = sfp_pkg::crc_byte(acc, d);
        end else begin
            r = acc + {8'h00, d};
        end
        return r;
    endfunction

    // Hold input while the queue is full or a frame waits to drain from payload memory
    assign s_ready = !q_full && !pend_reg;
    assign s_fire  = s_valid && s_ready;

    // Classify the type byte
    always_comb begin
        if (ftype_reg == cfg.code_start) begin
            kind = sfp_pkg::KIND_START;
        end else if (ftype_reg == cfg.code_stop) begin
            kind = sfp_pkg::KIND_STOP;
        end else if (ftype_reg == cfg.code_ping) begin
            kind = sfp_pkg::KIND_PING;
        end else if (ftype_reg == cfg.code_reset) begin
            kind = sfp_pkg::KIND_RESET;
        end else begin
            kind = sfp_pkg::KIND_UNKNOWN;
        end
    end

    // Decode one beat
    always_comb begin
        b            = s_rx_byte;
        skip         = 1'b0;
        unstuff_next = unstuff_reg;
        phase_next   = phase_reg;
        flen_next    = flen_reg;
        ftype_next   = ftype_reg;
        pcount_next  = pcount_reg;
        acc_next     = acc_reg;
        chk_hi_next  = chk_hi_reg;
        inv_next     = inv_reg;
        do_reject    = 1'b0;
        do_bump      = 1'b0;
        do_frame     = 1'b0;
        ram_wr_en    = 1'b0;
        chk_len      = cfg.checksum_mode ? 8'd3 : 8'd2;
        plen_lim     = flen_reg - chk_len;
        cmd          = '0;
        cmd.status   = sfp_pkg::STATUS_ABSORB;

        // Drop escapes and flip the escaped byte
        if (cfg.stuffing_enable) begin
            if (unstuff_reg) begin
                b            = s_rx_byte ^ sfp_pkg::ESC_XOR;
                unstuff_next = 1'b0;
            end else if (s_rx_byte == sfp_pkg::ESC_BYTE) begin
                unstuff_next = 1'b1;
                skip         = 1'b1;
            end
        end else begin
            unstuff_next = 1'b0;
        end

        if (!skip) begin
            case (phase_reg)
                PH_SYNC: begin
                    if (b == sfp_pkg::FRAME_FLAG) begin
                        phase_next = PH_LEN;
                    end else begin
                        do_bump = 1'b1;
                    end
                end
                PH_LEN: begin
                    if (b < cfg.length_minimum || b > cfg.length_maximum) begin
                        do_reject = 1'b1;
                    end else begin
                        flen_next   = b;
                        pcount_next = '0;
                        acc_next    = cfg.checksum_mode ?
                                      sfp_pkg::crc_byte(sfp_pkg::CRC_INIT, b) : {8'h00, b};
                        phase_next  = PH_TYPE;
                    end
                end
                PH_TYPE: begin
                    ftype_next  = b;
                    pcount_next = '0;
                    acc_next    = acc_add(cfg.checksum_mode, acc_reg, b);
                    phase_next  = PH_DATA;
                end
                PH_DATA: begin
                    if (flen_reg < chk_len) begin
                        do_reject = 1'b1;
                    end else if (8'(pcount_reg) < plen_lim) begin
                        if (32'(pcount_reg) >= PAYLOAD_DEPTH) begin
                            do_reject = 1'b1;
                        end else begin
                            ram_wr_en   = s_fire;
                            pcount_next = pcount_reg + CW'(1);
                            acc_next    = acc_add(cfg.checksum_mode, acc_reg, b);
                        end
                    end else if (cfg.checksum_mode) begin
                        chk_hi_next = b;
                        phase_next  = PH_CRCLO;
                    end else if (b != ~acc_reg[7:0]) begin
                        do_reject = 1'b1;
                    end else begin
                        do_frame = 1'b1;
                    end
                end
                PH_CRCLO: begin
                    if ({chk_hi_reg, b} != acc_reg) begin
                        do_reject = 1'b1;
                    end else begin
                        do_frame = 1'b1;
                    end
                end
                default: begin
                    do_reject = 1'b1;
                end
            endcase
        end

        // Reject: count it and go back to hunting for sync
        if (do_reject) begin
            do_bump    = 1'b1;
            phase_next = PH_SYNC;
            cmd.status = sfp_pkg::STATUS_REJECT;
        end
        if (do_bump && inv_reg != sfp_pkg::CNT_MAX) begin
            inv_next = inv_reg + 16'd1;
        end

        // Good frame: clear the counter and hand the frame to the back end
        if (do_frame) begin
            inv_next     = '0;
            phase_next   = PH_SYNC;
            cmd.is_frame = 1'b1;
            cmd.status   = sfp_pkg::STATUS_VALID;
            cmd.kind     = kind;
            cmd.ftype    = ftype_reg;
            cmd.plen     = sfp_pkg::PLEN_W'(pcount_reg);
        end
        cmd.inv_cnt = inv_next;
    end

    assign q_push      = s_fire;
    assign q_push_data = cmd;
    assign ram_wr_addr = pcount_reg[AW-1:0];
    assign ram_wr_data = b;

    // Frame pending: set on push of a frame, clear when the back end finishes it
    always_comb begin
        pend_next = pend_reg;
        if (s_fire && do_frame) begin
            pend_next = 1'b1;
        end else if (frame_done) begin
            pend_next = 1'b0;
        end
    end

    // Advance parse state on each accepted beat; the pending flag updates every cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_SYNC;
            unstuff_reg <= 1'b0;
            flen_reg    <= '0;
            ftype_reg   <= '0;
            pcount_reg  <= '0;
            acc_reg     <= '0;
            chk_hi_reg  <= '0;
            inv_reg     <= '0;
            pend_reg    <= 1'b0;
        end else begin
            pend_reg <= pend_next;
            if (s_fire) begin
                phase_reg   <= phase_next;
                unstuff_reg <= unstuff_next;
                flen_reg    <= flen_next;
                ftype_reg   <= ftype_next;
                pcount_reg  <= pcount_next;
                acc_reg     <= acc_next;
                chk_hi_reg  <= chk_hi_next;
                inv_reg     <= inv_next;
            end
        end
    end

`ifndef SYNTH
    a_pend_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> !s_ready)
        else $error("input taken while a frame drains");
    a_count_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(pcount_reg) <= PAYLOAD_DEPTH)
        else $error("payload count beyond memory depth");
`endif

endmodule

`default_nettype wire

FILE: src/sfp_queue.sv
// Two-entry command queue between the front end and the back end.
// Uses sfp_pkg::cmd_t.
`default_nettype none

module sfp_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire sfp_pkg::cmd_t push_data,
    output logic               full,
    input  wire logic          pop,
    output logic               head_valid,
    output sfp_pkg::cmd_t      head
);

    sfp_pkg::cmd_t slot_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    cnt_reg, cnt_next;

    assign full       = (cnt_reg == 2'd2);
    assign head_valid = (cnt_reg != 2'd0);
    assign head       = slot_reg[rd_ptr_reg];

    // Pointer and fill updates
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (pop) begin
            rd_ptr_next = !rd_ptr_reg;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the pushed command
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push || pop)
        else $error("push into a full command queue");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("pop from an empty command queue");
`endif

endmodule

`default_nettype wire

FILE: src/sfp_back.sv
// Back end: turns queued commands into result beats, reading a valid frame's
// payload out of the payload memory one byte at a time. Uses sfp_pkg.
`default_nettype none

module sfp_back #(
    parameter int PAYLOAD_DEPTH = sfp_pkg::DEFAULT_PAYLOAD_DEPTH
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         q_valid,
    input  wire sfp_pkg::cmd_t                q_head,
    output logic                              q_pop,
    output logic                              frame_done,
    output logic                              ram_rd_en,
    output logic [((PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1)-1:0] ram_rd_addr,
    input  wire logic [7:0]                   ram_rd_data,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [1:0]                        m_status,
    output logic [2:0]                        m_frame_kind,
    output logic [7:0]                        m_frame_type,
    output logic [sfp_pkg::PLEN_W-1:0]        m_payload_length,
    output logic [7:0]                        m_payload_byte,
    output logic                              m_last,
    output logic [15:0]                       m_invalid_count
);

    localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_READ = 2'd1;
    localparam logic [1:0] B_DATA = 2'd2;

    logic [1:0]                 state_reg, state_next;
    logic [AW-1:0]              idx_reg, idx_next;
    logic                       m_valid_reg, m_valid_next;
    logic [1:0]                 status_reg, status_next;
    logic [2:0]                 kind_reg, kind_next;
    logic [7:0]                 ftype_reg, ftype_next;
    logic [sfp_pkg::PLEN_W-1:0] plen_reg, plen_next;
    logic [7:0]                 pbyte_reg, pbyte_next;
    logic                       last_reg, last_next;
    logic [15:0]                inv_reg, inv_next;
    logic                       out_free;
    logic                       load;
    logic                       is_last;

    assign out_free = !m_valid_reg || m_ready;
    assign is_last  = (sfp_pkg::PLEN_W'(idx_reg) + sfp_pkg::PLEN_W'(1)) == q_head.plen;

    // Sequence commands into result beats
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        q_pop      = 1'b0;
        ram_rd_en  = 1'b0;
        load       = 1'b0;
        pbyte_next = 8'h00;
        last_next  = 1'b1;
        case (state_reg)
            B_IDLE: begin
                if (q_valid) begin
                    if (!q_head.is_frame || q_head.plen == '0) begin
                        if (out_free) begin
                            load  = 1'b1;
                            q_pop = 1'b1;
                        end
                    end else begin
                        idx_next   = '0;
                        state_next = B_READ;
                    end
                end
            end
            B_READ: begin
                ram_rd_en  = 1'b1;
                state_next = B_DATA;
            end
            B_DATA: begin
                if (out_free) begin
                    load       = 1'b1;
                    pbyte_next = ram_rd_data;
                    last_next  = is_last;
                    if (is_last) begin
                        q_pop      = 1'b1;
                        state_next = B_IDLE;
                    end else begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = B_READ;
                    end
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    assign frame_done  = q_pop && q_head.is_frame;
    assign ram_rd_addr = idx_reg;

    // Output register: load a new beat, drop the taken one
    always_comb begin
        m_valid_next = m_valid_reg;
        status_next  = status_reg;
        kind_next    = kind_reg;
        ftype_next   = ftype_reg;
        plen_next    = plen_reg;
        inv_next     = inv_reg;
        if (load) begin
            m_valid_next = 1'b1;
            status_next  = q_head.status;
            kind_next    = q_head.kind;
            ftype_next   = q_head.ftype;
            plen_next    = q_head.plen;
            inv_next     = q_head.inv_cnt;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Hold result fields
    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        kind_reg   <= kind_next;
        ftype_reg  <= ftype_next;
        plen_reg   <= plen_next;
        inv_reg    <= inv_next;
        if (load) begin
            pbyte_reg <= pbyte_next;
            last_reg  <= last_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = status_reg;
    assign m_frame_kind     = kind_reg;
    assign m_frame_type     = ftype_reg;
    assign m_payload_length = plen_reg;
    assign m_payload_byte   = pbyte_reg;
    assign m_last           = last_reg;
    assign m_invalid_count  = inv_reg;

`ifndef SYNTH
    a_drain_has_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_READ || state_reg == B_DATA) |-> (q_valid && q_head.is_frame))
        else $error("payload drain without a frame at queue head");
    a_single_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && status_reg != sfp_pkg::STATUS_VALID) |-> last_reg)
        else $error("absorb or reject beat not marked last");
`endif

endmodule

`default_nettype wire

FILE: src/sync_frame_parser_crc16_stuffing_top.sv
// Top level of the byte-stuffed frame parser: configuration registers, front
// end, command queue, payload memory and back end. Uses sfp_pkg and all sfp_ modules.
//
//  channel   direction  signals                                   beat
//  s_        in         s_valid/s_ready, s_rx_byte                one received byte
//  m_        out        m_valid/m_ready, status .. invalid_count   one result
//  cfg_      in         cfg_we, cfg_addr, cfg_wdata               one register write
//
//  An input byte is taken whenever the command queue has room and no frame waits to drain.
//  A byte that is absorbed or rejected yields one result through the queue and output register.
//  A valid frame drains its payload from the payload memory one result at a time
//  (address state, then registered read); input is held off meanwhile.
//  aresetn is synchronous and active low; the payload memory is not cleared.
//  Either side may stall at any time; the output register and queue decouple them.
`default_nettype none

module sync_frame_parser_crc16_stuffing_top #(
    parameter int PAYLOAD_DEPTH = sfp_pkg::DEFAULT_PAYLOAD_DEPTH
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_we,
    input  wire logic [2:0]                   cfg_addr,
    input  wire logic [7:0]                   cfg_wdata,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [7:0]                   s_rx_byte,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [1:0]                        m_status,
    output logic [2:0]                        m_frame_kind,
    output logic [7:0]                        m_frame_type,
    output logic [sfp_pkg::PLEN_W-1:0]        m_payload_length,
    output logic [7:0]                        m_payload_byte,
    output logic                              m_last,
    output logic [15:0]                       m_invalid_count
);

    localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

    sfp_pkg::cfg_t cfg_reg;
    sfp_pkg::cmd_t push_data;
    sfp_pkg::cmd_t head;
    logic          q_push;
    logic          q_full;
    logic          q_pop;
    logic          head_valid;
    logic          frame_done;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.checksum_mode   <= 1'b1;
            cfg_reg.stuffing_enable <= 1'b1;
            cfg_reg.length_minimum  <= 8'd3;
            cfg_reg.length_maximum  <= 8'd67;
            cfg_reg.code_start      <= 8'd1;
            cfg_reg.code_stop       <= 8'd2;
            cfg_reg.code_ping       <= 8'd3;
            cfg_reg.code_reset      <= 8'd4;
        end else if (cfg_we) begin
            case (cfg_addr)
                sfp_pkg::REG_CHECKSUM_MODE:   cfg_reg.checksum_mode   <= cfg_wdata[0];
                sfp_pkg::REG_STUFFING_ENABLE: cfg_reg.stuffing_enable <= cfg_wdata[0];
                sfp_pkg::REG_LENGTH_MINIMUM:  cfg_reg.length_minimum  <= cfg_wdata;
                sfp_pkg::REG_LENGTH_MAXIMUM:  cfg_reg.length_maximum  <= cfg_wdata;
                sfp_pkg::REG_CODE_START:      cfg_reg.code_start      <= cfg_wdata;
                sfp_pkg::REG_CODE_STOP:       cfg_reg.code_stop       <= cfg_wdata;
                sfp_pkg::REG_CODE_PING:       cfg_reg.code_ping       <= cfg_wdata;
                sfp_pkg::REG_CODE_RESET:      cfg_reg.code_reset      <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    sfp_front #(
        .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_rx_byte   (s_rx_byte),
        .q_push      (q_push),
        .q_push_data (push_data),
        .q_full      (q_full),
        .frame_done  (frame_done),
        .ram_wr_en   (wr_en),
        .ram_wr_addr (wr_addr),
        .ram_wr_data (wr_data)
    );

    sfp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_data  (push_data),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head       (head)
    );

    sfp_ram #(
        .WIDTH(8),
        .DEPTH(PAYLOAD_DEPTH)
    ) u_payload_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sfp_back #(
        .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_valid          (head_valid),
        .q_head           (head),
        .q_pop            (q_pop),
        .frame_done       (frame_done),
        .ram_rd_en        (rd_en),
        .ram_rd_addr      (rd_addr),
        .ram_rd_data      (rd_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_frame_kind     (m_frame_kind),
        .m_frame_type     (m_frame_type),
        .m_payload_length (m_payload_length),
        .m_payload_byte   (m_payload_byte),
        .m_last           (m_last),
        .m_invalid_count  (m_invalid_count)
    );

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
// Self-checking bench for sync_frame_parser_crc16_stuffing_top: drives raw link
// bytes, predicts every result beat in-bench and checks them in order.
// Depends on sfp_pkg and the parser RTL only.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import sfp_pkg::*;

    localparam int HALF_PERIOD = 6;
    localparam int DEPTH       = DEFAULT_PAYLOAD_DEPTH;
    localparam int QUIET_LIMIT = 3000;
    localparam int LONG_HOLD   = 600;

    typedef enum logic [2:0] {
        SEEK_SYNC, TAKE_LEN, TAKE_TYPE, TAKE_DATA, TAKE_CRC_LO
    } parse_state_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [2:0]        kind;
        logic [7:0]        ftype;
        logic [PLEN_W-1:0] plen;
        logic [7:0]        pbyte;
        logic              last;
        logic [15:0]       inv;
    } result_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_we = 1'b0;
    logic [2:0]        cfg_addr = REG_CHECKSUM_MODE;
    logic [7:0]        cfg_wdata = 8'h00;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [7:0]        s_rx_byte = 8'h00;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [1:0]        m_status;
    logic [2:0]        m_frame_kind;
    logic [7:0]        m_frame_type;
    logic [PLEN_W-1:0] m_payload_length;
    logic [7:0]        m_payload_byte;
    logic              m_last;
    logic [15:0]       m_invalid_count;

    sync_frame_parser_crc16_stuffing_top dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_frame_kind     (m_frame_kind),
        .m_frame_type     (m_frame_type),
        .m_payload_length (m_payload_length),
        .m_payload_byte   (m_payload_byte),
        .m_last           (m_last),
        .m_invalid_count  (m_invalid_count)
    );

    always begin
        #(HALF_PERIOD) aclk = 1'b1;
        #(HALF_PERIOD) aclk = 1'b0;
    end

    // Register mirror, starts at the reset values
    cfg_t cfg_m = '{checksum_mode: 1'b1, stuffing_enable: 1'b1,
                    length_minimum: 8'd3, length_maximum: 8'd67,
                    code_start: 8'd1, code_stop: 8'd2, code_ping: 8'd3, code_reset: 8'd4};

    // Parser mirror
    parse_state_t p_state = SEEK_SYNC;
    logic         esc_pend = 1'b0;
    logic [7:0]   flen = 8'h00;
    logic [7:0]   ftype_held = 8'h00;
    int           pcount = 0;
    logic [15:0]  acc = 16'h0000;
    logic [7:0]   crc_hi = 8'h00;
    logic [7:0]   pay_mem [DEPTH];
    logic [15:0]  inv_cnt = 16'h0000;

    logic [7:0]   rx_stream [$];
    result_t      exp_results [$];

    int  err_count = 0;
    int  esc_pct = 8;
    bit  tx_idle_en = 1'b1;
    bit  rx_idle_en = 1'b1;
    bit  hold_arm = 1'b0;
    bit  hold_done = 1'b0;
    int  hold_left = 0;
    int  tx_wait = 0;
    int  rx_stall = 0;
    int  quiet = 0;

    // ---------------------------------------------------------------- prediction

    // CRC-CCITT, one data bit at a time, MSB first
    function automatic logic [15:0] ccitt_step(input logic [15:0] c, input logic [7:0] d);
        logic        fb;
        logic [15:0] r;
        r = c;
        for (int k = 7; k >= 0; k--) begin
            fb = r[15] ^ d[k];
            r  = {r[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return r;
    endfunction

    task automatic fold_check(input logic [7:0] b);
        if (cfg_m.checksum_mode) begin
            acc = ccitt_step(acc, b);
        end else begin
            acc = acc + 16'(b);
        end
    endtask

    task automatic bump_invalid();
        if (inv_cnt != CNT_MAX) begin
            inv_cnt = inv_cnt + 16'd1;
        end
    endtask

    task automatic expect_single(input logic [1:0] st);
        result_t r;
        r        = '0;
        r.status = st;
        r.last   = 1'b1;
        r.inv    = inv_cnt;
        exp_results.push_back(r);
    endtask

    task automatic expect_reject();
        bump_invalid();
        p_state = SEEK_SYNC;
        expect_single(STATUS_REJECT);
    endtask

    // Good frame: one beat per payload byte, or a single beat when empty
    task automatic expect_frame();
        result_t     r;
        logic [2:0]  kind;
        int          n;
        if (ftype_held == cfg_m.code_start) begin
            kind = KIND_START;
        end else if (ftype_held == cfg_m.code_stop) begin
            kind = KIND_STOP;
        end else if (ftype_held == cfg_m.code_ping) begin
            kind = KIND_PING;
        end else if (ftype_held == cfg_m.code_reset) begin
            kind = KIND_RESET;
        end else begin
            kind = KIND_UNKNOWN;
        end
        inv_cnt = 16'h0000;
        p_state = SEEK_SYNC;
        n = (pcount > DEPTH) ? DEPTH : pcount;
        r        = '0;
        r.status = STATUS_VALID;
        r.kind   = kind;
        r.ftype  = ftype_held;
        r.plen   = PLEN_W'(n);
        r.inv    = inv_cnt;
        if (n == 0) begin
            r.last = 1'b1;
            exp_results.push_back(r);
        end else begin
            for (int i = 0; i < n; i++) begin
                r.pbyte = pay_mem[i];
                r.last  = (i == n - 1);
                exp_results.push_back(r);
            end
        end
    endtask

    task automatic parse_byte(input logic [7:0] raw);
        logic [7:0] b;
        logic [7:0] sum_want;
        int         chk;
        b = raw;
        // Strip escapes
        if (cfg_m.stuffing_enable) begin
            if (esc_pend) begin
                b        = b ^ ESC_XOR;
                esc_pend = 1'b0;
            end else if (b == ESC_BYTE) begin
                esc_pend = 1'b1;
                expect_single(STATUS_ABSORB);
                return;
            end
        end else begin
            esc_pend = 1'b0;
        end

        case (p_state)
            SEEK_SYNC: begin
                if (b == FRAME_FLAG) begin
                    p_state = TAKE_LEN;
                end else begin
                    bump_invalid();
                end
                expect_single(STATUS_ABSORB);
            end
            TAKE_LEN: begin
                if (b < cfg_m.length_minimum || b > cfg_m.length_maximum) begin
                    expect_reject();
                end else begin
                    flen    = b;
                    pcount  = 0;
                    acc     = cfg_m.checksum_mode ? CRC_INIT : 16'h0000;
                    fold_check(b);
                    p_state = TAKE_TYPE;
                    expect_single(STATUS_ABSORB);
                end
            end
            TAKE_TYPE: begin
                ftype_held = b;
                pcount     = 0;
                fold_check(b);
                p_state    = TAKE_DATA;
                expect_single(STATUS_ABSORB);
            end
            TAKE_DATA: begin
                chk = cfg_m.checksum_mode ? 2 : 1;
                if (int'(flen) < 1 + chk) begin
                    expect_reject();
                end else if (pcount < int'(flen) - (1 + chk)) begin
                    if (pcount >= DEPTH) begin
                        expect_reject();
                    end else begin
                        pay_mem[pcount] = b;
                        pcount++;
                        fold_check(b);
                        expect_single(STATUS_ABSORB);
                    end
                end else if (cfg_m.checksum_mode) begin
                    crc_hi  = b;
                    p_state = TAKE_CRC_LO;
                    expect_single(STATUS_ABSORB);
                end else begin
                    // Sum mode: this byte is the check itself
                    sum_want = ~acc[7:0];
                    if (b != sum_want) begin
                        expect_reject();
                    end else begin
                        expect_frame();
                    end
                end
            end
            TAKE_CRC_LO: begin
                if ({crc_hi, b} != acc) begin
                    expect_reject();
                end else begin
                    expect_frame();
                end
            end
            default: expect_reject();
        endcase
    endtask

    // ---------------------------------------------------------------- stimulus

    function automatic logic [7:0] rand_data();
        case ($urandom_range(0, 19))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return ESC_BYTE;
            3:       return FRAME_FLAG;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] pick_type();
        case ($urandom_range(0, 5))
            0:       return cfg_m.code_start;
            1:       return cfg_m.code_stop;
            2:       return cfg_m.code_ping;
            3:       return cfg_m.code_reset;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Queue one decoded byte; when the link stuffs, escape it if it is the escape byte, else at random
    task automatic send_byte(input logic [7:0] b);
        if (cfg_m.stuffing_enable && (b == ESC_BYTE || $urandom_range(0, 99) < esc_pct)) begin
            rx_stream.push_back(ESC_BYTE);
            rx_stream.push_back(b ^ ESC_XOR);
        end else begin
            rx_stream.push_back(b);
        end
    endtask

    task automatic push_frame(input logic [7:0] len_b, input logic [7:0] ft,
                              input int npay, input bit spoil);
        logic [7:0]  body [$];
        logic [15:0] crc;
        logic [7:0]  sum;
        body.push_back(len_b);
        body.push_back(ft);
        repeat (npay) body.push_back(rand_data());
        crc = CRC_INIT;
        sum = 8'h00;
        foreach (body[i]) begin
            crc = ccitt_step(crc, body[i]);
            sum = sum + body[i];
        end
        if (cfg_m.checksum_mode) begin
            body.push_back(crc[15:8]);
            body.push_back(crc[7:0]);
        end else begin
            body.push_back(~sum);
        end
        if (spoil) begin
            body[body.size() - 1] = body[body.size() - 1] ^ 8'($urandom_range(1, 255));
        end
        send_byte(FRAME_FLAG);
        foreach (body[i]) send_byte(body[i]);
    endtask

    // Mostly well-formed frames, the rest broken frames and line noise
    task automatic gen_traffic(input int budget);
        int         base;
        int         r;
        int         ovh;
        int         lo;
        int         hi;
        int         lb;
        int         lmin;
        int         lmax;
        base = rx_stream.size();
        while (rx_stream.size() - base < budget) begin
            r    = $urandom_range(0, 99);
            ovh  = cfg_m.checksum_mode ? 3 : 2;
            lmin = cfg_m.length_minimum;
            lmax = cfg_m.length_maximum;
            lo   = (lmin > ovh) ? lmin : ovh;
            hi   = (lmax < DEPTH + ovh) ? lmax : DEPTH + ovh;
            if (r < 74) begin
                if (lo > hi) begin
                    lb = $urandom_range(0, 255);
                    push_frame(8'(lb), pick_type(), $urandom_range(0, 4), 1'b0);
                end else begin
                    if ($urandom_range(0, 24) == 0) begin
                        lb = hi;
                    end else begin
                        lb = $urandom_range(lo, (hi < lo + 8) ? hi : lo + 8);
                    end
                    push_frame(8'(lb), pick_type(), lb - ovh, $urandom_range(0, 6) == 0);
                end
            end else if (r < 84) begin
                // length outside the window
                if (lmin > 0 && ($urandom_range(0, 1) == 0 || lmax == 255)) begin
                    lb = $urandom_range(0, lmin - 1);
                end else if (lmax < 255) begin
                    lb = $urandom_range(lmax + 1, 255);
                end else begin
                    lb = $urandom_range(0, 255);
                end
                push_frame(8'(lb), pick_type(), $urandom_range(0, 3), 1'b0);
            end else if (r < 88) begin
                // length too short to hold a check
                push_frame(8'($urandom_range(0, ovh - 1)), pick_type(),
                           $urandom_range(0, 2), 1'b0);
            end else if (r < 90) begin
                // payload longer than the store
                lb = $urandom_range(DEPTH + ovh + 1, 255);
                push_frame(8'(lb), pick_type(), DEPTH + 1, 1'b0);
            end else begin
                repeat ($urandom_range(1, 4)) rx_stream.push_back(rand_data());
            end
        end
    endtask

    // Leave the parser inside a frame so the next settings apply mid-frame
    task automatic push_partial_frame();
        send_byte(FRAME_FLAG);
        send_byte(8'd12);
        send_byte(pick_type());
        repeat (3) send_byte(rand_data());
    endtask

    // ---------------------------------------------------------------- config

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_CHECKSUM_MODE:   cfg_m.checksum_mode   = val[0];
            REG_STUFFING_ENABLE: cfg_m.stuffing_enable = val[0];
            REG_LENGTH_MINIMUM:  cfg_m.length_minimum  = val;
            REG_LENGTH_MAXIMUM:  cfg_m.length_maximum  = val;
            REG_CODE_START:      cfg_m.code_start      = val;
            REG_CODE_STOP:       cfg_m.code_stop       = val;
            REG_CODE_PING:       cfg_m.code_ping       = val;
            REG_CODE_RESET:      cfg_m.code_reset      = val;
            default: ;
        endcase
    endtask

    task automatic configure(input bit cm, input bit se, input logic [7:0] lmin,
                             input logic [7:0] lmax, input logic [7:0] c_start,
                             input logic [7:0] c_stop, input logic [7:0] c_ping,
                             input logic [7:0] c_reset);
        write_reg(REG_CHECKSUM_MODE, {7'd0, cm});
        write_reg(REG_STUFFING_ENABLE, {7'd0, se});
        write_reg(REG_LENGTH_MINIMUM, lmin);
        write_reg(REG_LENGTH_MAXIMUM, lmax);
        write_reg(REG_CODE_START, c_start);
        write_reg(REG_CODE_STOP, c_stop);
        write_reg(REG_CODE_PING, c_ping);
        write_reg(REG_CODE_RESET, c_reset);
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    // Wait until every byte is taken and every result beat has come back
    task automatic wait_drained();
        do begin
            @(negedge aclk);
        end while (rx_stream.size() != 0 || s_valid || exp_results.size() != 0);
    endtask

    // ---------------------------------------------------------------- checking

    task automatic note_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
        err_count++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    endtask

    task automatic check_result();
        result_t e;
        if (exp_results.size() == 0) begin
            err_count++;
            $display("%0t: result beat with none expected, actual status %0h byte %0h",
                     $time, m_status, m_payload_byte);
            return;
        end
        e = exp_results.pop_front();
        if (m_status != e.status) note_mismatch("status", e.status, m_status);
        if (m_frame_kind != e.kind) note_mismatch("frame_kind", e.kind, m_frame_kind);
        if (m_frame_type != e.ftype) note_mismatch("frame_type", e.ftype, m_frame_type);
        if (m_payload_length != e.plen) begin
            note_mismatch("payload_length", e.plen, m_payload_length);
        end
        if (m_payload_byte != e.pbyte) note_mismatch("payload_byte", e.pbyte, m_payload_byte);
        if (m_last != e.last) note_mismatch("last", e.last, m_last);
        if (m_invalid_count != e.inv) note_mismatch("invalid_count", e.inv, m_invalid_count);
    endtask

    // ---------------------------------------------------------------- processes

    // Byte driver: offer the next queued byte, hold it until taken
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid   <= 1'b0;
            s_rx_byte <= 8'h00;
            tx_wait   <= 0;
        end else begin
            if (s_valid && s_ready) begin
                parse_byte(s_rx_byte);
            end
            if (s_valid && !s_ready) begin
                // hold the beat
            end else if (tx_wait != 0) begin
                s_valid <= 1'b0;
                tx_wait <= tx_wait - 1;
            end else if (rx_stream.size() != 0) begin
                s_valid   <= 1'b1;
                s_rx_byte <= rx_stream.pop_front();
                tx_wait   <= (tx_idle_en && hold_left == 0) ? $urandom_range(0, 10) : 0;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result sink: check each beat, stall at random, one long hold-off
    always @(posedge aclk) begin : result_sink
        int stall;
        if (!aresetn) begin
            m_ready  <= 1'b0;
            rx_stall <= 0;
        end else begin
            stall = rx_stall;
            if (m_valid && m_ready) begin
                check_result();
                stall = rx_idle_en ? $urandom_range(0, 10) : 0;
            end
            if (hold_arm && !hold_done) begin
                hold_left <= LONG_HOLD;
                hold_done <= 1'b1;
                m_ready   <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_ready   <= 1'b0;
            end else if (stall != 0) begin
                stall   = stall - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
            rx_stall <= stall;
        end
    end

    // Watchdog: end the run when neither channel moves for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet <= 0;
            end else if (quiet >= QUIET_LIMIT) begin
                $display("%0t: no beat accepted for %0d cycles", $time, QUIET_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end else begin
                quiet <= quiet + 1;
            end
        end
    end

    initial begin
        logic [7:0] junk;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: reset settings, junk, empty frame, fully escaped frame,
        // bad length and bad CRC
        rx_stream.push_back(8'h00);
        rx_stream.push_back(8'hFF);
        push_frame(8'd3, cfg_m.code_start, 0, 1'b0);
        esc_pct = 100;
        push_frame(8'd4, cfg_m.code_stop, 1, 1'b0);
        esc_pct = 8;
        send_byte(FRAME_FLAG);
        send_byte(8'd2);
        push_frame(8'd3, cfg_m.code_ping, 0, 1'b1);
        wait_drained();

        // CRC, stuffing on, default window; receiver holds off once
        configure(1'b1, 1'b1, 8'd3, 8'd67, 8'd1, 8'd2, 8'd3, 8'd4);
        gen_traffic(80);
        hold_arm = 1'b1;
        wait_drained();

        // Sum mode, full length window, extreme codes; ends mid-frame
        configure(1'b0, 1'b1, 8'd0, 8'd255, 8'h00, 8'hFF, 8'h80, ESC_BYTE);
        gen_traffic(80);
        push_partial_frame();
        wait_drained();

        // CRC, stuffing off, all codes equal, no idling
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        configure(1'b1, 1'b0, 8'd0, 8'd255, 8'd5, 8'd5, 8'd5, 8'd5);
        repeat (8) send_byte(rand_data());
        gen_traffic(70);
        push_partial_frame();
        wait_drained();

        // Sum mode, stuffing off, narrow window, random codes
        tx_idle_en = 1'b1;
        configure(1'b0, 1'b0, 8'd10, 8'd20, 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
        repeat (8) send_byte(rand_data());
        gen_traffic(60);
        wait_drained();

        // Empty window: every frame rejects
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b1;
        configure(1'b1, 1'b1, 8'd255, 8'd0, 8'd1, 8'd2, 8'd3, 8'd4);
        gen_traffic(20);
        wait_drained();

        // Run the invalid counter up on line noise, then clear it with a good frame
        rx_idle_en = 1'b0;
        configure(1'b1, 1'b0, 8'd3, 8'd67, 8'd1, 8'd2, 8'd3, 8'd4);
        repeat (30) begin
            junk = 8'($urandom_range(0, 255));
            rx_stream.push_back((junk == FRAME_FLAG) ? 8'h00 : junk);
        end
        push_frame(8'd5, cfg_m.code_reset, 2, 1'b0);
        rx_stream.push_back(8'h55);
        wait_drained();

        // Let any stray beat surface before the verdict
        repeat (20) @(posedge aclk);
        if (err_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
